[rtl/core/fdtp_pkg.sv]
// Shared types and constants for the device tree structure token parser.
`default_nettype none

package fdtp_pkg;

  // Structure-block tokens
  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_NOP        = 32'd4;
  localparam logic [31:0] TOK_END        = 32'd9;

  // Name offset value that disables a match
  localparam logic [31:0] OFFSET_NONE = 32'hFFFF_FFFF;

  // Value word counter
  localparam int unsigned WORDS_W = 30;
  localparam logic [WORDS_W-1:0] WORDS_MAX = {WORDS_W{1'b1}};

  // Configuration register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_START_OFFSET = 1'b0;
  localparam logic REG_END_OFFSET   = 1'b1;

  // Result event codes
  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_END   = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;

  typedef enum logic [2:0] {
    PH_TOKEN   = 3'd0,
    PH_NAME    = 3'd1,
    PH_LEN     = 3'd2,
    PH_NAMEOFF = 3'd3,
    PH_VALUE   = 3'd4,
    PH_SKIP    = 3'd5,
    PH_DONE    = 3'd6
  } fdtp_phase_t;

  typedef enum logic [1:0] {
    MATCH_NONE  = 2'd0,
    MATCH_START = 2'd1,
    MATCH_END   = 2'd2
  } fdtp_match_t;

  // One parse result handed from the parse core to the result register
  typedef struct packed {
    logic        hit;
    logic [1:0]  ev;
    logic [31:0] value;
    logic [31:0] held_start;
    logic [31:0] held_end;
  } fdtp_res_t;

endpackage

`default_nettype wire

[rtl/core/fdtp_parse.sv]
// Parse state and per-word token decode for the structure block.
`default_nettype none

module fdtp_parse
  import fdtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic [31:0] word,
  input  wire logic        first_word,
  input  wire logic [31:0] start_off,
  input  wire logic [31:0] end_off,
  output fdtp_res_t        res
);

  fdtp_phase_t        phase_r, phase_nxt;
  fdtp_match_t        match_r, match_nxt;
  logic [WORDS_W-1:0] left_r, left_nxt;
  logic [31:0]        cap_start_r, cap_start_nxt;
  logic [31:0]        cap_end_r, cap_end_nxt;

  fdtp_phase_t        ph_cur;
  fdtp_match_t        mt_cur;
  logic [WORDS_W-1:0] left_cur;
  logic [WORDS_W-1:0] left_dec;
  logic [32:0]        len_sum;
  logic [WORDS_W:0]   len_words;
  logic               zero_byte;
  logic               start_hit;
  logic               end_hit;

  // Restart on the first word of a blob
  assign ph_cur   = first_word ? PH_TOKEN : phase_r;
  assign mt_cur   = first_word ? MATCH_NONE : match_r;
  assign left_cur = first_word ? '0 : left_r;
  assign left_dec = left_cur - {{(WORDS_W-1){1'b0}}, 1'b1};

  // Round the byte length up to words
  assign len_sum   = {1'b0, word} + 33'd3;
  assign len_words = len_sum[32:2];

  assign zero_byte = (word[31:24] == 8'h00) || (word[23:16] == 8'h00) ||
                     (word[15:8] == 8'h00) || (word[7:0] == 8'h00);
  assign start_hit = (start_off != OFFSET_NONE) && (word == start_off);
  assign end_hit   = (end_off != OFFSET_NONE) && (word == end_off);

  // Decode one word
  always_comb begin
    phase_nxt     = ph_cur;
    match_nxt     = mt_cur;
    left_nxt      = left_cur;
    cap_start_nxt = cap_start_r;
    cap_end_nxt   = cap_end_r;
    res.hit       = 1'b0;
    res.ev        = EV_DONE;
    res.value     = '0;
    case (ph_cur)
      PH_TOKEN: begin
        if (word == TOK_BEGIN_NODE) begin
          phase_nxt = PH_NAME;
        end else if (word == TOK_PROP) begin
          phase_nxt = PH_LEN;
        end else if (word == TOK_END) begin
          phase_nxt = PH_DONE;
          res.hit   = 1'b1;
          res.ev    = EV_DONE;
        end
      end
      PH_NAME: begin
        if (zero_byte) begin
          phase_nxt = PH_TOKEN;
        end
      end
      PH_LEN: begin
        left_nxt  = len_words[WORDS_W] ? WORDS_MAX : len_words[WORDS_W-1:0];
        phase_nxt = PH_NAMEOFF;
      end
      PH_NAMEOFF: begin
        if (left_cur == '0) begin
          match_nxt = MATCH_NONE;
          phase_nxt = PH_TOKEN;
        end else begin
          if (start_hit) begin
            match_nxt = MATCH_START;
          end else if (end_hit) begin
            match_nxt = MATCH_END;
          end else begin
            match_nxt = MATCH_NONE;
          end
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        match_nxt = MATCH_NONE;
        left_nxt  = left_dec;
        phase_nxt = (left_dec == '0) ? PH_TOKEN : PH_SKIP;
        if (mt_cur == MATCH_START) begin
          cap_start_nxt = word;
          res.hit       = 1'b1;
          res.ev        = EV_START;
          res.value     = word;
        end else if (mt_cur == MATCH_END) begin
          cap_end_nxt = word;
          res.hit     = 1'b1;
          res.ev      = EV_END;
          res.value   = word;
        end
      end
      PH_SKIP: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_TOKEN;
        end
      end
      default: begin
        // done: drop words until restart
        phase_nxt = ph_cur;
      end
    endcase
    res.held_start = cap_start_nxt;
    res.held_end   = cap_end_nxt;
  end

  // Advance parse state once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TOKEN;
      match_r     <= MATCH_NONE;
      left_r      <= '0;
      cap_start_r <= '0;
      cap_end_r   <= '0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      match_r     <= match_nxt;
      left_r      <= left_nxt;
      cap_start_r <= cap_start_nxt;
      cap_end_r   <= cap_end_nxt;
    end
  end

  // End token always parks the parser in the done phase
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.hit && (res.ev == EV_DONE) |=> phase_r == PH_DONE)
    else $error("end token did not enter done phase");

  // A start capture updates the held start value with the word
  a_start_cap: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.hit && (res.ev == EV_START) |=> cap_start_r == $past(word))
    else $error("start capture not held");

  // Skipped value words and node name words never produce a result
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !first_word && (phase_r == PH_SKIP || phase_r == PH_NAME) |-> !res.hit)
    else $error("result raised while skipping");

  // Entering the value phase needs words left to consume
  a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (phase_nxt == PH_VALUE) |=> left_r != '0)
    else $error("value phase entered with no words");

endmodule

`default_nettype wire

[rtl/core/fdt_structure_token_parser_top.sv]
// Top level of the device tree structure token parser with its register port.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   in_word, in_first_word
//   out_     output     out_valid/out_stall out_event_res, out_value,
//                                           out_held_start, out_held_end
//   cfg      input      psel/penable/pready start and end name offsets
//
// One word is accepted per cycle while in_stall is low; a result passes through the
// input register and the result register around the decode.
// Reset clears parse state, captured values and both offsets to none.
// A stalled result holds the result register and, once the input register is
// also full, raises in_stall; no word is lost or repeated.
`default_nettype none

module fdt_structure_token_parser_top
  import fdtp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input words
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [31:0]           in_word,
  input  wire logic                  in_first_word,
  // results
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_event_res,
  output logic [31:0]                out_value,
  output logic [31:0]                out_held_start,
  output logic [31:0]                out_held_end,
  // register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic        rd_sel;
  logic [31:0] start_off_q_r;
  logic [31:0] end_off_r;
  logic        s1_valid_r;
  logic [31:0] s1_word_r;
  logic        s1_first_r;
  logic        out_valid_r;
  fdtp_res_t   out_res_r;
  fdtp_res_t   res;
  logic        out_free;
  logic        adv;
  logic        in_take;
  logic        cfg_wr;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign rd_sel = paddr[2];
  assign prdata = (rd_sel == REG_END_OFFSET) ? end_off_r : start_off_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_off_q_r <= OFFSET_NONE;
      end_off_r     <= OFFSET_NONE;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_START_OFFSET) begin
        start_off_q_r <= pwdata;
      end else begin
        end_off_r <= pwdata;
      end
    end
  end

  // Pipeline flow
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r  <= in_word;
      s1_first_r <= in_first_word;
    end
  end

  fdtp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .word       (s1_word_r),
    .first_word (s1_first_r),
    .start_off  (start_off_q_r),
    .end_off    (end_off_r),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.hit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.hit) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_res_r.ev;
  assign out_value      = out_res_r.value;
  assign out_held_start = out_res_r.held_start;
  assign out_held_end   = out_res_r.held_end;

  // Stall only when the input register is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("stall raised with empty input register");

  // A decoded result with no room never advances
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !adv)
    else $error("result overwritten while stalled");

  // Every advancing hit shows up as a valid result next cycle
  a_hit_shown: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.hit |=> out_valid_r)
    else $error("decoded result lost");

endmodule

`default_nettype wire

[test/tb_fdt_structure_token_parser_top.sv]
// Testbench for the device tree structure token parser: directed rows, random blobs, scoreboard.
`timescale 1ns / 1ps

module tb_fdt_structure_token_parser_top
  import fdtp_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [1:0]  ev;
    logic [31:0] value;
    logic [31:0] held_start;
    logic [31:0] held_end;
  } parse_event_t;

  typedef struct packed {
    logic [31:0]  w;
    logic         first;
    logic         typed;
    parse_event_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [31:0]           in_word;
  logic                  in_first_word;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_event_res;
  logic [31:0]           out_value;
  logic [31:0]           out_held_start;
  logic [31:0]           out_held_end;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  fdt_structure_token_parser_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .in_first_word  (in_first_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_value      (out_value),
    .out_held_start (out_held_start),
    .out_held_end   (out_held_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Parser shadow state and register copies
  fdtp_phase_t        ph;
  fdtp_match_t        match_kind;
  logic [WORDS_W-1:0] words_left;
  logic [31:0]        cap_start;
  logic [31:0]        cap_end;
  logic [31:0]        cfg_start_off;
  logic [31:0]        cfg_end_off;

  parse_event_t pending_events[$];
  parse_event_t head_event;
  dir_row_t     dir_rows[$];
  int           failures = 0;
  int           words_sent = 0;
  int           snd_left = 0;
  bit           snd_calm = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Draw a random wait, with calm stretches that never wait
  function automatic int pick_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // Advance the shadow parser by one word; return 1 when it reports an event
  function automatic bit step_parser(input logic [31:0] w, input logic first,
                                     output parse_event_t r);
    logic [32:0] count;
    fdtp_match_t kind;
    bit          hit;
    hit = 1'b0;
    r = '0;
    if (first) begin
      ph = PH_TOKEN;
      words_left = '0;
      match_kind = MATCH_NONE;
    end
    case (ph)
      PH_TOKEN: begin
        if (w == TOK_BEGIN_NODE) ph = PH_NAME;
        else if (w == TOK_PROP) ph = PH_LEN;
        else if (w == TOK_END) begin
          ph = PH_DONE;
          r.ev = EV_DONE;
          hit = 1'b1;
        end
      end
      PH_NAME: begin
        if (w[31:24] == 8'h00 || w[23:16] == 8'h00 || w[15:8] == 8'h00 || w[7:0] == 8'h00)
          ph = PH_TOKEN;
      end
      PH_LEN: begin
        count = ({1'b0, w} + 33'd3) >> 2;
        words_left = (count > {3'b0, WORDS_MAX}) ? WORDS_MAX : count[WORDS_W-1:0];
        ph = PH_NAMEOFF;
      end
      PH_NAMEOFF: begin
        if (words_left == '0) begin
          match_kind = MATCH_NONE;
          ph = PH_TOKEN;
        end else begin
          if (cfg_start_off != OFFSET_NONE && w == cfg_start_off) match_kind = MATCH_START;
          else if (cfg_end_off != OFFSET_NONE && w == cfg_end_off) match_kind = MATCH_END;
          else match_kind = MATCH_NONE;
          ph = PH_VALUE;
        end
      end
      PH_VALUE: begin
        kind = match_kind;
        match_kind = MATCH_NONE;
        words_left = words_left - 1'b1;
        ph = (words_left == '0) ? PH_TOKEN : PH_SKIP;
        if (kind == MATCH_START) begin
          cap_start = w;
          r.ev = EV_START;
          r.value = w;
          hit = 1'b1;
        end else if (kind == MATCH_END) begin
          cap_end = w;
          r.ev = EV_END;
          r.value = w;
          hit = 1'b1;
        end
      end
      PH_SKIP: begin
        words_left = words_left - 1'b1;
        if (words_left == '0) ph = PH_TOKEN;
      end
      default: ;
    endcase
    r.held_start = cap_start;
    r.held_end = cap_end;
    return hit;
  endfunction

  // Offer one item after a random gap; queue its result once it is taken
  task automatic send_word(input logic [31:0] w, input logic first, input logic typed,
                           input parse_event_t want);
    int           gap;
    parse_event_t r;
    gap = pick_wait(snd_left, snd_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    in_first_word <= first;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (step_parser(w, first, r)) begin
      if (!typed) pending_events.push_back(r);
    end
    if (typed) pending_events.push_back(want);
  endtask

  task automatic put_word(input logic [31:0] w, input logic first);
    send_word(w, first, 1'b0, '0);
  endtask

  task automatic add_row(input logic [31:0] w, input logic first, input logic typed,
                         input logic [1:0] ev, input logic [31:0] val,
                         input logic [31:0] hs, input logic [31:0] he);
    dir_row_t r;
    r.w = w;
    r.first = first;
    r.typed = typed;
    r.want = '{ev, val, hs, he};
    dir_rows.push_back(r);
  endtask

  // Register port transfers; psel stays up between back-to-back transfers
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apb_read(input logic [CFG_ADDR_W-1:0] addr, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
  endtask

  task automatic set_offsets(input logic [31:0] s_off, input logic [31:0] e_off);
    logic [31:0] rd;
    apb_write({REG_START_OFFSET, 2'b00}, s_off);
    apb_write({REG_END_OFFSET, 2'b00}, e_off);
    apb_read({REG_START_OFFSET, 2'b00}, rd);
    if (rd !== s_off) begin
      $error("start_name_offset readback: expected %h, got %h", s_off, rd);
      failures++;
    end
    apb_read({REG_END_OFFSET, 2'b00}, rd);
    if (rd !== e_off) begin
      $error("end_name_offset readback: expected %h, got %h", e_off, rd);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_start_off = s_off;
    cfg_end_off = e_off;
  endtask

  // Stop offering, wait for every queued result, then let the pipeline settle
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_events.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_events.size() != 0) begin
      $error("%0d expected results never arrived", pending_events.size());
      failures++;
      pending_events.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  // Node name: some words without a null byte, then one holding a null byte
  task automatic send_name();
    logic [31:0] w;
    repeat ($urandom_range(0, 2)) begin
      w = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
           8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
      put_word(w, 1'b0);
    end
    w = $urandom;
    w[8*$urandom_range(0, 3) +: 8] = 8'h00;
    put_word(w, 1'b0);
  endtask

  // One blob: mostly well formed with random content, sometimes noise or cut short
  task automatic send_blob();
    logic [31:0] len;
    logic [31:0] off;
    int          pick;
    int          nval;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) put_word($urandom, 1'($urandom_range(0, 1)));
      return;
    end
    put_word(TOK_BEGIN_NODE, 1'b1);
    send_name();
    for (int e = 0; e < $urandom_range(1, 12); e++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          put_word(TOK_BEGIN_NODE, 1'b0);
          send_name();
        end
        2, 3, 4, 5: begin
          put_word(TOK_PROP, 1'b0);
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            len = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFD + $urandom_range(0, 2)
                                              : ($urandom | 32'h8000_0000);
          end else if (pick == 1) len = $urandom_range(17, 64);
          else len = $urandom_range(0, 16);
          put_word(len, 1'b0);
          case ($urandom_range(0, 3))
            0: off = cfg_start_off;
            1: off = cfg_end_off;
            2: off = OFFSET_NONE;
            default: off = $urandom;
          endcase
          put_word(off, 1'b0);
          // drop a huge property part way; the next blob restarts the parser
          if (pick == 0) begin
            repeat ($urandom_range(1, 4)) put_word($urandom, 1'b0);
            return;
          end
          nval = (len + 3) / 4;
          if ($urandom_range(0, 19) == 0) nval = $urandom_range(0, nval);
          repeat (nval) put_word($urandom, 1'b0);
        end
        6: put_word(TOK_END_NODE, 1'b0);
        7, 8: put_word(TOK_NOP, 1'b0);
        default: put_word($urandom, 1'b0);
      endcase
    end
    put_word(TOK_END, 1'b0);
    repeat ($urandom_range(0, 3)) put_word($urandom, 1'b0);
  endtask

  task automatic run_setting(input logic [31:0] s_off, input logic [31:0] e_off, input int n);
    int base;
    drain();
    set_offsets(s_off, e_off);
    base = words_sent;
    while (words_sent - base < n) send_blob();
  endtask

  // Result side: random stall per item, with long hold-offs to fill the block
  initial begin
    int n;
    int left;
    int taken;
    bit calm;
    left = 0;
    taken = 0;
    calm = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 20 || taken == 120) n = LONG_HOLD;
      else n = pick_wait(left, calm);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: event_res %0d value %h", out_event_res, out_value);
        failures++;
      end else begin
        head_event = pending_events.pop_front();
        if (out_event_res !== head_event.ev) begin
          $error("event_res: expected %0d, got %0d", head_event.ev, out_event_res);
          failures++;
        end
        if (out_value !== head_event.value) begin
          $error("value: expected %h, got %h", head_event.value, out_value);
          failures++;
        end
        if (out_held_start !== head_event.held_start) begin
          $error("held_start: expected %h, got %h", head_event.held_start, out_held_start);
          failures++;
        end
        if (out_held_end !== head_event.held_end) begin
          $error("held_end: expected %h, got %h", head_event.held_end, out_held_end);
          failures++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    ph = PH_TOKEN;
    match_kind = MATCH_NONE;
    words_left = '0;
    cap_start = '0;
    cap_end = '0;
    cfg_start_off = OFFSET_NONE;
    cfg_end_off = OFFSET_NONE;
    in_valid <= 1'b0;
    in_word <= '0;
    in_first_word <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_offsets(32'h10, 32'h20);

    // end token right after reset, then an ignored word after it
    add_row(TOK_END, 1'b1, 1'b1, EV_DONE, 32'h0, 32'h0, 32'h0);
    add_row(TOK_END, 1'b0, 1'b0, '0, '0, '0, '0);
    // node name skipped through the word holding a null byte
    add_row(TOK_BEGIN_NODE, 1'b1, 1'b0, '0, '0, '0, '0);
    add_row(32'h4142_4344, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'h4546_0000, 1'b0, 1'b0, '0, '0, '0, '0);
    // start property with an all-ones value
    add_row(TOK_PROP, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'h4, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'h10, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'hFFFF_FFFF, 1'b0, 1'b1, EV_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    // empty property on the end offset captures nothing
    add_row(TOK_PROP, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'h0, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'h20, 1'b0, 1'b0, '0, '0, '0, '0);
    // end property, two value words
    add_row(TOK_PROP, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'h8, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'h20, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'h0, 1'b0, 1'b1, EV_END, 32'h0, 32'hFFFF_FFFF, 32'h0);
    add_row(32'h1234_5678, 1'b0, 1'b0, '0, '0, '0, '0);
    // end-node, no-op and an unknown token are passed over
    add_row(TOK_END_NODE, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(TOK_NOP, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'hDEAD_BEEF, 1'b0, 1'b0, '0, '0, '0, '0);
    // saturated length, then restart in the middle of the property
    add_row(TOK_PROP, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'h30, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(32'h55, 1'b0, 1'b0, '0, '0, '0, '0);
    add_row(TOK_END, 1'b1, 1'b1, EV_DONE, 32'h0, 32'hFFFF_FFFF, 32'h0);

    foreach (dir_rows[i])
      send_word(dir_rows[i].w, dir_rows[i].first, dir_rows[i].typed, dir_rows[i].want);

    // random blobs under several offset settings
    run_setting(OFFSET_NONE, 32'h0, 120);
    run_setting(32'h5, 32'h5, 120);
    run_setting(32'h0, OFFSET_NONE, 120);
    run_setting(OFFSET_NONE, OFFSET_NONE, 100);
    run_setting($urandom, $urandom, 120);
    run_setting(32'hFFFF_FFFE, 32'h7FFF_FFFF, 120);
    drain();

    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
